### hw/rtl/indexed_list_store_defines.svh
// Assertion macros used by the port-level checker.
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ILS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled during reset.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### hw/rtl/ils_pkg.sv
// Package: command and status codes, field widths, controller/datapath structs.
package ils_pkg;

	localparam int CMD_W  = 3;
	localparam int IDX_W  = 7;
	localparam int VAL_W  = 32;
	localparam int ST_W   = 3;
	localparam int FIDX_W = 6;
	localparam int CNT_W  = 7;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [ST_W-1:0] ST_BADIDX   = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic            latch;
		logic            set_status;
		logic [ST_W-1:0] status;
		logic            mem_append;
		logic            cnt_dec;
		logic            cnt_clr;
		logic            shift_init;
		logic            shift_step;
		logic            ins_write;
		logic            find_init;
		logic            find_step;
		logic            find_take;
		logic            rd_capture;
		logic            publish;
	} ils_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             empty;
		logic             full;
		logic             idx_gt;
		logic             idx_ge;
		logic             shift_done;
		logic             find_hit;
		logic             find_done;
		logic             out_free;
	} ils_stat_t;

endpackage

### hw/rtl/ils_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ils_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/ils_ctrl.sv
// Controller: sequences each transaction through decode, shift/scan loops and result hand-off.
module ils_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ils_pkg::ils_stat_t st,
	output ils_pkg::ils_cmd_t  cm
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_EXEC    = 3'd1;
	localparam logic [2:0] S_SHIFT   = 3'd2;
	localparam logic [2:0] S_INS_WR  = 3'd3;
	localparam logic [2:0] S_RD_WAIT = 3'd4;
	localparam logic [2:0] S_FIND    = 3'd5;
	localparam logic [2:0] S_DONE    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cm        = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cm.latch  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				cm.set_status = 1'b1;
				cm.status     = ils_pkg::ST_OK;
				state_nxt     = S_DONE;
				unique case (st.cmd)
					ils_pkg::CMD_APPEND: begin
						if (st.full) begin
							cm.status = ils_pkg::ST_FULL;
						end else begin
							cm.mem_append = 1'b1;
						end
					end
					ils_pkg::CMD_INSERT: begin
						if (st.idx_gt) begin
							cm.status = ils_pkg::ST_BADIDX;
						end else if (st.full) begin
							cm.status = ils_pkg::ST_FULL;
						end else begin
							cm.shift_init = 1'b1;
							state_nxt     = S_SHIFT;
						end
					end
					ils_pkg::CMD_REMOVE: begin
						if (st.empty) begin
							cm.status = ils_pkg::ST_EMPTY;
						end else begin
							cm.cnt_dec = 1'b1;
						end
					end
					ils_pkg::CMD_READ: begin
						if (st.empty) begin
							cm.status = ils_pkg::ST_EMPTY;
						end else if (st.idx_ge) begin
							cm.status = ils_pkg::ST_BADIDX;
						end else begin
							state_nxt = S_RD_WAIT;
						end
					end
					ils_pkg::CMD_FIND: begin
						cm.find_init = 1'b1;
						state_nxt    = S_FIND;
					end
					ils_pkg::CMD_CLEAR: begin
						cm.cnt_clr = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_SHIFT: begin
				if (st.shift_done) begin
					state_nxt = S_INS_WR;
				end else begin
					cm.shift_step = 1'b1;
				end
			end
			S_INS_WR: begin
				cm.ins_write = 1'b1;
				state_nxt    = S_DONE;
			end
			S_RD_WAIT: begin
				cm.rd_capture = 1'b1;
				state_nxt     = S_DONE;
			end
			S_FIND: begin
				if (st.find_hit) begin
					cm.find_take = 1'b1;
					state_nxt    = S_DONE;
				end else if (st.find_done) begin
					cm.set_status = 1'b1;
					cm.status     = ils_pkg::ST_NOTFOUND;
					state_nxt     = S_DONE;
				end else begin
					cm.find_step = 1'b1;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cm.publish = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

### hw/rtl/ils_dp.sv
// Datapath: entry RAM, count, shift/scan pointer, result and output registers.
module ils_dp #(
	parameter int CAPACITY  = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ils_pkg::CMD_W-1:0]         cmd,
	input  logic [ils_pkg::IDX_W-1:0]         index,
	input  logic signed [ils_pkg::VAL_W-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ils_pkg::ST_W-1:0]          status,
	output logic signed [ils_pkg::VAL_W-1:0]  read_value,
	output logic [ils_pkg::FIDX_W-1:0]        found_index,
	output logic [ils_pkg::CNT_W-1:0]         count,
	input  ils_pkg::ils_cmd_t                 cm,
	output ils_pkg::ils_stat_t                st
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > ils_pkg::IDX_W) ? CW : ils_pkg::IDX_W;

	logic [ils_pkg::CMD_W-1:0]       cmd_q;
	logic [ils_pkg::IDX_W-1:0]       idx_q;
	logic [WORD_BITS-1:0]            word_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   ptr_q;
	logic                            pend_s1;
	logic [AW-1:0]                   addr_s1;
	logic [ils_pkg::ST_W-1:0]        status_q;
	logic [ils_pkg::VAL_W-1:0]       rd_q;
	logic [AW-1:0]                   fidx_q;
	logic                            out_valid_q;
	logic [ils_pkg::ST_W-1:0]        out_status_q;
	logic [ils_pkg::VAL_W-1:0]       out_rd_q;
	logic [ils_pkg::FIDX_W-1:0]      out_fidx_q;
	logic [ils_pkg::CNT_W-1:0]       out_count_q;

	logic [XW-1:0]        idx_w;
	logic [XW-1:0]        cnt_w;
	logic [XW-1:0]        ptr_w;
	logic                 shift_more;
	logic                 find_more;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [AW-1:0]        raddr;
	logic [WORD_BITS-1:0] rdata;

	assign idx_w = XW'(idx_q);
	assign cnt_w = XW'(count_q);
	assign ptr_w = XW'(ptr_q);

	assign shift_more = (ptr_w > idx_w);
	assign find_more  = (ptr_q < count_q);

	always_comb begin
		we    = 1'b0;
		waddr = AW'(count_q);
		wdata = word_q;
		if (cm.mem_append) begin
			we = 1'b1;
		end else if (cm.ins_write) begin
			we    = 1'b1;
			waddr = AW'(idx_w);
		end else if (cm.shift_step && pend_s1) begin
			we    = 1'b1;
			waddr = addr_s1;
			wdata = rdata;
		end
	end

	always_comb begin
		raddr = AW'(idx_w);
		if (cm.shift_step) begin
			raddr = AW'(ptr_q - CW'(1));
		end else if (cm.find_step) begin
			raddr = AW'(ptr_q);
		end
	end

	ils_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cm.latch) begin
			cmd_q  <= cmd;
			idx_q  <= index;
			word_q <= WORD_BITS'(value);
		end
		if (cm.set_status) begin
			status_q <= cm.status;
			rd_q     <= '0;
			fidx_q   <= '0;
		end
		if (cm.rd_capture) begin
			rd_q <= ils_pkg::VAL_W'(signed'(rdata));
		end
		if (cm.find_take) begin
			fidx_q <= addr_s1;
		end
		if (cm.publish) begin
			out_status_q <= status_q;
			out_rd_q     <= rd_q;
			out_fidx_q   <= ils_pkg::FIDX_W'(fidx_q);
			out_count_q  <= ils_pkg::CNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			pend_s1     <= 1'b0;
			addr_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cm.cnt_clr) begin
				count_q <= '0;
			end else if (cm.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end else if (cm.mem_append || cm.ins_write) begin
				count_q <= count_q + CW'(1);
			end

			if (cm.shift_init) begin
				ptr_q   <= count_q;
				pend_s1 <= 1'b0;
			end else if (cm.find_init) begin
				ptr_q   <= '0;
				pend_s1 <= 1'b0;
			end else if (cm.shift_step) begin
				pend_s1 <= shift_more;
				if (shift_more) begin
					addr_s1 <= AW'(ptr_q);
					ptr_q   <= ptr_q - CW'(1);
				end
			end else if (cm.find_step) begin
				pend_s1 <= find_more;
				if (find_more) begin
					addr_s1 <= AW'(ptr_q);
					ptr_q   <= ptr_q + CW'(1);
				end
			end

			if (cm.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.cmd        = cmd_q;
	assign st.empty      = (count_q == '0);
	assign st.full       = (count_q >= CW'(CAPACITY));
	assign st.idx_gt     = (idx_w > cnt_w);
	assign st.idx_ge     = (idx_w >= cnt_w);
	assign st.shift_done = !shift_more && !pend_s1;
	assign st.find_hit   = pend_s1 && (rdata == word_q);
	assign st.find_done  = !find_more && !pend_s1;
	assign st.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign read_value  = out_rd_q;
	assign found_index = out_fidx_q;
	assign count       = out_count_q;

endmodule

### hw/rtl/indexed_list_store.sv
// Top level: bounded list store with append, insert, remove, read, find and clear.
//
//  channel | signals                                  | role
//  --------+------------------------------------------+-----------------------------
//  in      | in_valid in_ready cmd index value         | one command per transaction
//  out     | out_valid out_ready status read_value     | one result per command
//          | found_index count                        |
//
// Append, remove, clear and unused codes finish in the execute state; read waits for the RAM read data.
// Insert shifts the entries from index up by one place, one entry moved per cycle, then writes the new entry.
// Find scans the entries from index zero up to the first match, or to the end of the list on a miss.
// Reset clears the count and all control; store contents stay undefined until written.
// A result waits in the output register; the next command is taken while it stalls.
module indexed_list_store #(
	parameter int CAPACITY  = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ils_pkg::CMD_W-1:0]         cmd,
	input  logic [ils_pkg::IDX_W-1:0]         index,
	input  logic signed [ils_pkg::VAL_W-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ils_pkg::ST_W-1:0]          status,
	output logic signed [ils_pkg::VAL_W-1:0]  read_value,
	output logic [ils_pkg::FIDX_W-1:0]        found_index,
	output logic [ils_pkg::CNT_W-1:0]         count
);

	ils_pkg::ils_cmd_t  cm;
	ils_pkg::ils_stat_t st;

	ils_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.st      (st),
		.cm      (cm)
	);

	ils_dp #(
		.CAPACITY (CAPACITY),
		.WORD_BITS(WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.index      (index),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.read_value (read_value),
		.found_index(found_index),
		.count      (count),
		.cm         (cm),
		.st         (st)
	);

endmodule

### hw/rtl/ils_chk.sv
// Port-level checker for indexed_list_store, attached by bind.
`include "indexed_list_store_defines.svh"

module ils_chk #(
	parameter int CAPACITY = 64
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [ils_pkg::CMD_W-1:0]         cmd,
	input logic [ils_pkg::IDX_W-1:0]         index,
	input logic signed [ils_pkg::VAL_W-1:0]  value,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [ils_pkg::ST_W-1:0]          status,
	input logic signed [ils_pkg::VAL_W-1:0]  read_value,
	input logic [ils_pkg::FIDX_W-1:0]        found_index,
	input logic [ils_pkg::CNT_W-1:0]         count
);

	`ILS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(read_value) && $stable(found_index) && $stable(count), "result changed while stalled")

	`ILS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second transaction taken while busy")

	`ILS_ASSERT_SAME(a_rd_zero, out_valid && (status != ils_pkg::ST_OK), (read_value == '0) && (found_index == '0), "non-ok result carries data")

	`ILS_ASSERT_SAME(a_count_cap, out_valid, int'(count) <= CAPACITY, "count above capacity")

endmodule

bind indexed_list_store ils_chk #(.CAPACITY(CAPACITY)) u_ils_chk (.*);
